@@ hdl/two_line_relation_intersect_unit_assert.svh @@
// Assertion macros shared by the line intersection unit.
// Each macro takes a label, clock, reset, antecedent and consequent.
`ifndef TWO_LINE_RELATION_INTERSECT_UNIT_ASSERT_SVH
`define TWO_LINE_RELATION_INTERSECT_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TLRI_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlri assertion failed");

// Next-cycle implication.
`define TLRI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlri assertion failed");

`endif

@@ hdl/tlri_pkg.sv @@
// Package for the line intersection unit: widths, codes and the item record
// passed from the classifying front end to the division back end.
package tlri_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int COORD_W = 16;
   localparam int DELTA_W = 17;
   localparam int CPROD_W = 32;
   localparam int C_W     = 33;
   localparam int DPROD_W = 34;
   localparam int DEN_W   = 35;
   localparam int NPROD_W = 50;
   localparam int NUM_W   = 51;
   localparam int QUOT_W  = 48;
   // Back end tag pipeline: magnitude stage, setup stage, one stage per quotient bit.
   localparam int DIV_LAT = QUOT_W + 2;
   localparam int QUEUE_DEPTH = 4;

   localparam logic signed [QUOT_W-1:0] QUOT_MAX = {1'b0, {(QUOT_W-1){1'b1}}};
   localparam logic signed [QUOT_W-1:0] QUOT_MIN = {1'b1, {(QUOT_W-1){1'b0}}};

   typedef enum logic [1:0] {
      REL_PARALLEL  = 2'd0,
      REL_PERP      = 2'd1,
      REL_INTERSECT = 2'd2,
      REL_DEGEN     = 2'd3
   } relation_type;

   typedef struct packed {
      relation_type             relation;
      logic signed [C_W-1:0]     ca;
      logic signed [C_W-1:0]     cb;
      logic signed [DEN_W-1:0]   den;
      logic signed [DELTA_W-1:0] dxa;
      logic signed [DELTA_W-1:0] dya;
      logic signed [DELTA_W-1:0] dxb;
      logic signed [DELTA_W-1:0] dyb;
   } tlri_item_type;

endpackage

@@ hdl/tlri_if.sv @@
// Valid/ready channel interfaces for the line intersection unit.
// Depends on tlri_pkg for the relation code type.
interface tlri_req_if;
   logic              valid;
   logic              ready;
   logic signed [15:0] line_a_x0;
   logic signed [15:0] line_a_y0;
   logic signed [15:0] line_a_x1;
   logic signed [15:0] line_a_y1;
   logic signed [15:0] line_b_x0;
   logic signed [15:0] line_b_y0;
   logic signed [15:0] line_b_x1;
   logic signed [15:0] line_b_y1;

   modport source (output valid, line_a_x0, line_a_y0, line_a_x1, line_a_y1,
                   line_b_x0, line_b_y0, line_b_x1, line_b_y1, input ready);
   modport sink (input valid, line_a_x0, line_a_y0, line_a_x1, line_a_y1,
                 line_b_x0, line_b_y0, line_b_x1, line_b_y1, output ready);
endinterface

interface tlri_rsp_if;
   logic                 valid;
   logic                 ready;
   tlri_pkg::relation_type relation;
   logic signed [47:0]   cross_x;
   logic signed [47:0]   cross_y;
   logic                 saturated;

   modport source (output valid, relation, cross_x, cross_y, saturated, input ready);
   modport sink (input valid, relation, cross_x, cross_y, saturated, output ready);
endinterface

@@ hdl/two_line_relation_intersect_unit.sv @@
// Top level of the two-line relation and intersection unit.
// Depends on tlri_pkg, tlri_if, tlri_front, tlri_queue, tlri_back and the assert header.

// Each transaction carries two lines given by two integer points and returns one
// result: parallel, perpendicular, intersecting, or degenerate when a line is
// vertical or its points share an x coordinate. Intersecting pairs report the
// crossing point in signed fixed point with FRAC_BITS fraction bits, truncated
// toward zero and clipped to 48 bits with the saturated flag set; all other
// classes return zero coordinates. The unit accepts one transaction per cycle
// while results drain and holds no state between them. Each item passes through
// three front-end stages, one slot of the four-entry queue, two numerator
// stages, the 50-stage divider (one quotient bit per stage for 48 bits plus
// two setup stages) and the output register; the divider is most of the depth.
module two_line_relation_intersect_unit
   import tlri_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   tlri_req_if.sink   req,
   tlri_rsp_if.source rsp
);

`include "two_line_relation_intersect_unit_assert.svh"

   logic          f_valid, f_ready;
   tlri_item_type f_item;
   logic          q_valid, q_ready;
   tlri_item_type q_item;

   logic          rsp_other, rsp_zero, rsp_clipped;

   tlri_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_item  (f_item)
   );

   tlri_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_item   (f_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   tlri_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (q_valid),
      .in_ready (q_ready),
      .in_item  (q_item),
      .rsp      (rsp)
   );

   assign rsp_other   = rsp.valid && rsp.relation != REL_INTERSECT;
   assign rsp_zero    = rsp.cross_x == '0 && rsp.cross_y == '0 && !rsp.saturated;
   assign rsp_clipped = rsp.cross_x == QUOT_MAX || rsp.cross_x == QUOT_MIN ||
                        rsp.cross_y == QUOT_MAX || rsp.cross_y == QUOT_MIN;

   `TLRI_ASSERT_NOW(a_zero_unless_cross, clock, reset, rsp_other, rsp_zero)
   `TLRI_ASSERT_NOW(a_sat_clipped, clock, reset, rsp.valid && rsp.saturated, rsp_clipped)
   `TLRI_ASSERT_NEXT(a_queue_holds, clock, reset, q_valid && !q_ready, q_valid)

endmodule

@@ hdl/tlri_front.sv @@
// Front end: takes line pairs, forms deltas and cross products, classifies.
// Depends on tlri_pkg and tlri_req_if; feeds tlri_queue.
module tlri_front
   import tlri_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   tlri_req_if.sink      req,
   output logic          out_valid,
   input  logic          out_ready,
   output tlri_item_type out_item
);

   logic fe;
   logic v1_ff, v2_ff, v3_ff;

   logic signed [COORD_W-1:0] xa0_ff, ya0_ff, xa1_ff, ya1_ff;
   logic signed [COORD_W-1:0] xb0_ff, yb0_ff, xb1_ff, yb1_ff;
   logic signed [DELTA_W-1:0] dxa1_ff, dya1_ff, dxb1_ff, dyb1_ff;

   logic signed [DELTA_W-1:0] dxa2_ff, dya2_ff, dxb2_ff, dyb2_ff;
   logic signed [DPROD_W-1:0] p_par0_ff, p_par1_ff, p_perp0_ff, p_perp1_ff;
   logic signed [CPROD_W-1:0] pa0_ff, pa1_ff, pb0_ff, pb1_ff;

   logic signed [DEN_W-1:0] den_in, perp_in;
   relation_type            rel_in;
   tlri_item_type           item_ff;

   // The whole front advances together unless the last stage cannot drain.
   assign fe        = !v3_ff || out_ready;
   assign req.ready = fe;
   assign out_valid = v3_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (fe) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fe) begin
         xa0_ff  <= req.line_a_x0;
         ya0_ff  <= req.line_a_y0;
         xa1_ff  <= req.line_a_x1;
         ya1_ff  <= req.line_a_y1;
         xb0_ff  <= req.line_b_x0;
         yb0_ff  <= req.line_b_y0;
         xb1_ff  <= req.line_b_x1;
         yb1_ff  <= req.line_b_y1;
         dxa1_ff <= DELTA_W'(req.line_a_x1) - DELTA_W'(req.line_a_x0);
         dya1_ff <= DELTA_W'(req.line_a_y1) - DELTA_W'(req.line_a_y0);
         dxb1_ff <= DELTA_W'(req.line_b_x1) - DELTA_W'(req.line_b_x0);
         dyb1_ff <= DELTA_W'(req.line_b_y1) - DELTA_W'(req.line_b_y0);

         dxa2_ff    <= dxa1_ff;
         dya2_ff    <= dya1_ff;
         dxb2_ff    <= dxb1_ff;
         dyb2_ff    <= dyb1_ff;
         p_par0_ff  <= dya1_ff * dxb1_ff;
         p_par1_ff  <= dyb1_ff * dxa1_ff;
         p_perp0_ff <= dya1_ff * dyb1_ff;
         p_perp1_ff <= dxa1_ff * dxb1_ff;
         pa0_ff     <= ya0_ff * xa1_ff;
         pa1_ff     <= ya1_ff * xa0_ff;
         pb0_ff     <= yb0_ff * xb1_ff;
         pb1_ff     <= yb1_ff * xb0_ff;

         item_ff.relation <= rel_in;
         item_ff.ca       <= C_W'(pa0_ff) - C_W'(pa1_ff);
         item_ff.cb       <= C_W'(pb0_ff) - C_W'(pb1_ff);
         item_ff.den      <= den_in;
         item_ff.dxa      <= dxa2_ff;
         item_ff.dya      <= dya2_ff;
         item_ff.dxb      <= dxb2_ff;
         item_ff.dyb      <= dyb2_ff;
      end
   end

   assign den_in  = DEN_W'(p_par0_ff) - DEN_W'(p_par1_ff);
   assign perp_in = DEN_W'(p_perp0_ff) + DEN_W'(p_perp1_ff);

   always_comb begin
      if (dxa2_ff == '0 || dxb2_ff == '0) begin
         rel_in = REL_DEGEN;
      end else if (den_in == '0) begin
         rel_in = REL_PARALLEL;
      end else if (perp_in == '0) begin
         rel_in = REL_PERP;
      end else begin
         rel_in = REL_INTERSECT;
      end
   end

endmodule

@@ hdl/tlri_queue.sv @@
// Small FIFO that decouples the classifying front end from the divider back end.
// Depends on tlri_pkg for the item record.
module tlri_queue
   import tlri_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  tlri_item_type in_item,
   output logic          out_valid,
   input  logic          out_ready,
   output tlri_item_type out_item
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   tlri_item_type    mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push, pop;

   assign in_ready  = count_ff != CNT_W'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_item  = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_item;
      end
   end

endmodule

@@ hdl/tlri_div.sv @@
// Pipelined restoring divider: num/den scaled by 2^FRAC_BITS, truncated toward
// zero and saturated to 48 bits. One quotient bit per stage. Depends on tlri_pkg.
module tlri_div
   import tlri_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [NUM_W-1:0]  num,
   input  logic signed [DEN_W-1:0]  den,
   output logic signed [QUOT_W-1:0] quot,
   output logic                     sat
);

   localparam int SH_W = NUM_W + FRAC_BITS;

   logic [NUM_W-1:0] an_ff;
   logic [DEN_W-1:0] adm_ff;
   logic             negm_ff;
   logic [SH_W-1:0]  shifted;

   logic [DEN_W-1:0]  rem_ff [QUOT_W+1];
   logic [QUOT_W-1:0] nlo_ff [QUOT_W+1];
   logic [QUOT_W-1:0] q_ff   [QUOT_W+1];
   logic [DEN_W-1:0]  ad_ff  [QUOT_W+1];
   logic              neg_ff [QUOT_W+1];
   logic              big_ff [QUOT_W+1];

   logic [QUOT_W-1:0] mag;
   logic              over;

   always_ff @(posedge clock) begin
      if (en) begin
         an_ff   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
         adm_ff  <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
         negm_ff <= num[NUM_W-1] ^ den[DEN_W-1];
      end
   end

   assign shifted = SH_W'(an_ff) << FRAC_BITS;

   // The quotient fits in 48 bits exactly when the bits above them are below den.
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= DEN_W'(shifted[SH_W-1:QUOT_W]);
         nlo_ff[0] <= shifted[QUOT_W-1:0];
         q_ff[0]   <= '0;
         ad_ff[0]  <= adm_ff;
         neg_ff[0] <= negm_ff;
         big_ff[0] <= DEN_W'(shifted[SH_W-1:QUOT_W]) >= adm_ff;
      end
   end

   for (genvar i = 1; i <= QUOT_W; i++) begin : g_bit
      logic [DEN_W:0] trial;
      logic           ge;

      assign trial = {rem_ff[i-1], nlo_ff[i-1][QUOT_W-1]};
      assign ge    = trial >= {1'b0, ad_ff[i-1]};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= ge ? DEN_W'(trial - {1'b0, ad_ff[i-1]}) : DEN_W'(trial);
            nlo_ff[i] <= nlo_ff[i-1] << 1;
            q_ff[i]   <= {q_ff[i-1][QUOT_W-2:0], ge};
            ad_ff[i]  <= ad_ff[i-1];
            neg_ff[i] <= neg_ff[i-1];
            big_ff[i] <= big_ff[i-1];
         end
      end
   end

   assign mag  = q_ff[QUOT_W];
   assign over = big_ff[QUOT_W] ||
                 (neg_ff[QUOT_W] ? (mag > QUOT_W'(QUOT_MIN)) : mag[QUOT_W-1]);

   always_comb begin
      if (over) begin
         quot = neg_ff[QUOT_W] ? QUOT_MIN : QUOT_MAX;
      end else if (neg_ff[QUOT_W]) begin
         quot = -$signed(mag);
      end else begin
         quot = $signed(mag);
      end
   end

   assign sat = over;

endmodule

@@ hdl/tlri_back.sv @@
// Back end: forms the two numerators, divides them by the determinant and
// holds the result transaction. Depends on tlri_pkg, tlri_div and tlri_rsp_if.
module tlri_back
   import tlri_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  tlri_item_type in_item,
   tlri_rsp_if.source    rsp
);

   logic en;

   logic                      v1_ff, v2_ff;
   relation_type              rel1_ff, rel2_ff;
   logic signed [DEN_W-1:0]   den1_ff, den2_ff;
   logic signed [NPROD_W-1:0] cbdxa_ff, cadxb_ff, cbdya_ff, cadyb_ff;
   logic signed [NUM_W-1:0]   numx_ff, numy_ff;

   logic                      vld_pipe_ff [DIV_LAT];
   relation_type              rel_pipe_ff [DIV_LAT];

   logic signed [QUOT_W-1:0]  qx, qy;
   logic                      satx, saty;

   logic                      rsp_valid_ff;
   relation_type              rsp_rel_ff;
   logic signed [QUOT_W-1:0]  rsp_x_ff, rsp_y_ff;
   logic                      rsp_sat_ff;

   // Everything behind the output register moves only when it can drain.
   assign en       = !rsp_valid_ff || rsp.ready;
   assign in_ready = en;

   always_ff @(posedge clock) begin
      if (en) begin
         rel1_ff  <= in_item.relation;
         den1_ff  <= in_item.den;
         cbdxa_ff <= in_item.cb * in_item.dxa;
         cadxb_ff <= in_item.ca * in_item.dxb;
         cbdya_ff <= in_item.cb * in_item.dya;
         cadyb_ff <= in_item.ca * in_item.dyb;

         rel2_ff  <= rel1_ff;
         den2_ff  <= den1_ff;
         numx_ff  <= NUM_W'(cbdxa_ff) - NUM_W'(cadxb_ff);
         numy_ff  <= NUM_W'(cbdya_ff) - NUM_W'(cadyb_ff);
      end
   end

   tlri_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
      .clock (clock), .en (en), .num (numx_ff), .den (den2_ff),
      .quot  (qx),    .sat (satx)
   );

   tlri_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
      .clock (clock), .en (en), .num (numy_ff), .den (den2_ff),
      .quot  (qy),    .sat (saty)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         rel_pipe_ff[0] <= rel2_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            rel_pipe_ff[i] <= rel_pipe_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < DIV_LAT; i++) begin
            vld_pipe_ff[i] <= 1'b0;
         end
      end else if (en) begin
         v1_ff          <= in_valid;
         v2_ff          <= v1_ff;
         vld_pipe_ff[0] <= v2_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            vld_pipe_ff[i] <= vld_pipe_ff[i-1];
         end
         rsp_valid_ff   <= vld_pipe_ff[DIV_LAT-1];
      end
   end

   // Only intersecting pairs carry a point; all other classes report zeros.
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_rel_ff <= rel_pipe_ff[DIV_LAT-1];
         if (rel_pipe_ff[DIV_LAT-1] == REL_INTERSECT) begin
            rsp_x_ff   <= qx;
            rsp_y_ff   <= qy;
            rsp_sat_ff <= satx || saty;
         end else begin
            rsp_x_ff   <= '0;
            rsp_y_ff   <= '0;
            rsp_sat_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.relation  = rsp_rel_ff;
   assign rsp.cross_x   = rsp_x_ff;
   assign rsp.cross_y   = rsp_y_ff;
   assign rsp.saturated = rsp_sat_ff;

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for two_line_relation_intersect_unit.
// Depends on tlri_pkg and the tlri_req_if and tlri_rsp_if interfaces of the RTL.
module testbench;
   import tlri_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = FRAC_BITS_DEF;
   localparam longint unsigned POS_MAX = 64'h7FFF_FFFF_FFFF;
   localparam longint unsigned NEG_MAG = 64'h8000_0000_0000;
   localparam int HOLD_LEN = 400;

   typedef struct {
      logic signed [15:0] xa0, ya0, xa1, ya1, xb0, yb0, xb1, yb1;
   } line_pair_type;

   typedef struct {
      relation_type       relation;
      logic signed [47:0] cross_x;
      logic signed [47:0] cross_y;
      logic               saturated;
   } crossing_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tlri_req_if req ();
   tlri_rsp_if rsp ();

   two_line_relation_intersect_unit #(.FRAC_BITS(FRAC)) uut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   always #1 clock = ~clock;

   line_pair_type pending_pairs[$];
   crossing_type  expected_crossings[$];
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_cycles;
   logic hold_armed;
   logic hold_go = 1'b0;
   int errors = 0;

   // Magnitude divide scaled by 2^FRAC, truncated toward zero, clipped to 48 bits.
   function automatic logic [47:0] scaled_quotient(longint num, longint den, inout logic sat);
      logic neg;
      longint unsigned an, ad, q, r, mag;
      logic over;
      neg = (num < 0) != (den < 0);
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      q = an / ad;
      r = an % ad;
      over = 1'b0;
      mag = 0;
      if (q > (NEG_MAG >> FRAC)) begin
         over = 1'b1;
      end else begin
         mag = (q << FRAC) + ((r << FRAC) / ad);
         if (neg ? (mag > NEG_MAG) : (mag > POS_MAX)) over = 1'b1;
      end
      if (over) begin
         sat = 1'b1;
         return neg ? NEG_MAG[47:0] : POS_MAX[47:0];
      end
      return neg ? 48'(0 - mag) : mag[47:0];
   endfunction

   function automatic crossing_type predict_crossing(line_pair_type p);
      crossing_type c;
      longint dxa, dya, dxb, dyb, ca, cb, den;
      logic sat;
      dxa = longint'(p.xa1) - p.xa0;
      dya = longint'(p.ya1) - p.ya0;
      dxb = longint'(p.xb1) - p.xb0;
      dyb = longint'(p.yb1) - p.yb0;
      c.cross_x = '0;
      c.cross_y = '0;
      sat = 1'b0;
      if (dxa == 0 || dxb == 0) begin
         c.relation = REL_DEGEN;
      end else if (dya * dxb == dyb * dxa) begin
         c.relation = REL_PARALLEL;
      end else if (dya * dyb == -(dxa * dxb)) begin
         c.relation = REL_PERP;
      end else begin
         ca = longint'(p.ya0) * p.xa1 - longint'(p.ya1) * p.xa0;
         cb = longint'(p.yb0) * p.xb1 - longint'(p.yb1) * p.xb0;
         den = dya * dxb - dyb * dxa;
         c.relation = REL_INTERSECT;
         c.cross_x = scaled_quotient(cb * dxa - ca * dxb, den, sat);
         c.cross_y = scaled_quotient(cb * dya - ca * dyb, den, sat);
      end
      c.saturated = sat;
      return c;
   endfunction

   // Driver: a new transaction is offered once the previous one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         {req.line_a_x0, req.line_a_y0, req.line_a_x1, req.line_a_y1} <= '0;
         {req.line_b_x0, req.line_b_y0, req.line_b_x1, req.line_b_y1} <= '0;
      end else if (!req.valid || req.ready) begin
         if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            line_pair_type p;
            p = pending_pairs.pop_front();
            req.valid <= 1'b1;
            req.line_a_x0 <= p.xa0;
            req.line_a_y0 <= p.ya0;
            req.line_a_x1 <= p.xa1;
            req.line_a_y1 <= p.ya1;
            req.line_b_x0 <= p.xb0;
            req.line_b_y0 <= p.yb0;
            req.line_b_x1 <= p.xb1;
            req.line_b_y1 <= p.yb1;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, started once on request and counted down here.
   always @(posedge clock) begin
      if (reset) begin
         hold_cycles <= 0;
         hold_armed  <= 1'b1;
      end else if (hold_armed && hold_go) begin
         hold_cycles <= HOLD_LEN;
         hold_armed  <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
      end
   end

   // Result side: ready pattern and the checker.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (hold_cycles > 0) begin
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_crossings.size() == 0) begin
               $error("result transaction with no expectation waiting");
               errors++;
            end else begin
               crossing_type e;
               e = expected_crossings.pop_front();
               if (rsp.relation !== e.relation) begin
                  $error("relation: expected %0d actual %0d", e.relation, rsp.relation);
                  errors++;
               end
               if (rsp.cross_x !== e.cross_x) begin
                  $error("cross_x: expected %0d actual %0d", e.cross_x, rsp.cross_x);
                  errors++;
               end
               if (rsp.cross_y !== e.cross_y) begin
                  $error("cross_y: expected %0d actual %0d", e.cross_y, rsp.cross_y);
                  errors++;
               end
               if (rsp.saturated !== e.saturated) begin
                  $error("saturated: expected %0d actual %0d", e.saturated, rsp.saturated);
                  errors++;
               end
            end
         end
         if (req.valid && req.ready) begin
            line_pair_type p;
            p.xa0 = req.line_a_x0;
            p.ya0 = req.line_a_y0;
            p.xa1 = req.line_a_x1;
            p.ya1 = req.line_a_y1;
            p.xb0 = req.line_b_x0;
            p.yb0 = req.line_b_y0;
            p.xb1 = req.line_b_x1;
            p.yb1 = req.line_b_y1;
            expected_crossings.push_back(predict_crossing(p));
         end
      end
   end

   function automatic line_pair_type make_pair(int xa0, int ya0, int xa1, int ya1,
                                               int xb0, int yb0, int xb1, int yb1);
      line_pair_type p;
      p.xa0 = 16'(xa0); p.ya0 = 16'(ya0); p.xa1 = 16'(xa1); p.ya1 = 16'(ya1);
      p.xb0 = 16'(xb0); p.yb0 = 16'(yb0); p.xb1 = 16'(xb1); p.yb1 = 16'(yb1);
      return p;
   endfunction

   function automatic int small_val(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // Mostly shaped pairs that reach the degenerate, parallel, perpendicular and crossing
   // branches; some are small random values and the rest are raw full-range values.
   function automatic line_pair_type random_pair();
      line_pair_type p;
      int kind, xa0, ya0, dxa, dya, xb0, yb0, k;
      kind = $urandom_range(0, 9);
      xa0 = small_val(1000);
      ya0 = small_val(1000);
      dxa = small_val(100);
      dya = small_val(100);
      if (dxa == 0) dxa = 1;
      if (dya == 0) dya = -1;
      xb0 = small_val(1000);
      yb0 = small_val(1000);
      k = $urandom_range(1, 3);
      case (kind)
         0, 1: begin
            p = make_pair($urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom);
         end
         2: begin
            p = make_pair(xa0, ya0, xa0 + dxa, ya0 + dya,
                          xb0, yb0, xb0 + k * dxa, yb0 + k * dya);
         end
         3: begin
            p = make_pair(xa0, ya0, xa0 + dxa, ya0 + dya,
                          xb0, yb0, xb0 - k * dya, yb0 + k * dxa);
         end
         4: begin
            p = make_pair(xa0, ya0, xa0 + dxa, ya0 + dya,
                          xb0, yb0, xb0 + ($urandom_range(0, 1) ? 0 : dxa), yb0 + dya);
            if ($urandom_range(0, 1)) p.xa1 = p.xa0;
         end
         5: begin
            p = make_pair(small_val(20), small_val(20), small_val(20), small_val(20),
                          small_val(20), small_val(20), small_val(20), small_val(20));
         end
         default: begin
            p = make_pair(xa0, ya0, xa0 + dxa, ya0 + dya,
                          xb0, yb0, xb0 + small_val(100), yb0 + small_val(100));
         end
      endcase
      return p;
   endfunction

   task automatic run_phase(int count, int idle_pct, int stall_pct);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (count) pending_pairs.push_back(random_pair());
      while (pending_pairs.size() > 0 || req.valid || expected_crossings.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: vertical lines, coincident points, each class, field extremes.
      pending_pairs.push_back(make_pair(5, 0, 5, 9, 0, 0, 1, 1));
      pending_pairs.push_back(make_pair(0, 0, 1, 1, -3, 2, -3, 7));
      pending_pairs.push_back(make_pair(4, 4, 4, 4, 0, 0, 2, 3));
      pending_pairs.push_back(make_pair(0, 0, 2, 2, 1, 0, 3, 2));
      pending_pairs.push_back(make_pair(0, 0, 1, 2, 5, 5, 7, 4));
      pending_pairs.push_back(make_pair(0, 0, 2, 1, 0, 3, 3, 0));
      pending_pairs.push_back(make_pair(0, 0, 1, 0, 0, 1, 1, 1));
      pending_pairs.push_back(make_pair(0, 0, 3, 1, 0, 1, 3, -1));
      pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767,
                                        -32768, -32767, 32767, 32767));
      pending_pairs.push_back(make_pair(-32768, 32767, 32767, -32768,
                                        -32768, 32766, 32767, -32768));
      pending_pairs.push_back(make_pair(-32768, 0, 32767, 1, -32768, 1, 32767, 3));
      pending_pairs.push_back(make_pair(32767, 32767, -32768, -32768,
                                        -32768, 32767, 32767, -32767));
      pending_pairs.push_back(make_pair(-32768, -32768, -32768, -32768,
                                        32767, 32767, 32767, 32767));
      pending_pairs.push_back(make_pair(-1, -1, 0, 0, 32767, -32768, -32768, 32767));
      pending_pairs.push_back(make_pair(1, 2, 3, 5, -7, 11, 13, -17));
      pending_pairs.push_back(make_pair(0, 0, 1, 1, 0, 1, 1, 3));
      pending_pairs.push_back(make_pair(-32768, 32767, 32767, 32767, 0, -32768, 1, 32767));
      while (pending_pairs.size() > 0 || req.valid || expected_crossings.size() > 0)
         @(posedge clock);

      // The receiver holds off while items keep coming, so the unit backs up.
      hold_go <= 1'b1;
      run_phase(150, 0, 0);
      run_phase(350, 0, 0);
      run_phase(300, 83, 0);
      run_phase(300, 0, 83);
      run_phase(300, 16, 16);

      repeat (120) @(posedge clock);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end
endmodule
